// ===== rtl/ffha_pkg.sv =====
// shared constants and types for the first-fit heap allocator
// no dependencies; imported by first_fit_heap_allocator
package ffha_pkg;

  localparam int ADDR_W = 17;                    // arena byte address incl. end point
  localparam int SIZE_W = 17;                    // payload size in bytes
  localparam int OFF_W  = 16;
  localparam int IDX_W  = 13;                    // one header slot per 8-byte granule
  localparam int ENTRY_W = SIZE_W + 1;           // {size, alloc}

  localparam logic [ADDR_W-1:0] HEAP_BYTES  = 17'h10000;
  localparam logic [ADDR_W-1:0] HDR_BYTES   = 17'd40;
  localparam logic [ADDR_W-1:0] ALIGN_LOW   = 17'd7;
  localparam logic [ADDR_W-1:0] SPLIT_SLACK = 17'd48;   // header plus one alignment unit
  localparam logic [SIZE_W-1:0] INIT_SIZE   = 17'd65496;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_BAD_OFF = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_A_CHK,
    S_A_SPLIT,
    S_F_WALK,
    S_F_NXT,
    S_F_PREV,
    S_RESP
  } state_t;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// first-fit heap allocator with coalescing of adjacent free blocks
// depends on ffha_pkg; holds the header store memory and the walk sequencer
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_stall, command, request_bytes,   | request
//          | payload_offset                                |
//  out     | out_valid, out_stall, status, result_offset,  | response
//          | granted_bytes                                 |
//
// one transaction is handled at a time; a header is visited per cycle through
// the single read port of the header store. an allocate walks the headers in
// address order to the first fit, or to the arena end on no fit, and writes a
// split remainder in its own state; a free walks the headers in front of the
// target, then rewrites it with any forward merge and, on a back merge, the
// header in front of it. an oversized request or an offset below the header
// size goes straight to the response, and every accept is taken in idle.
// after reset the init state writes the whole-arena free block into slot 0.
// a waiting response holds the sequencer in the response state until the
// output register frees up; input is stalled whenever the sequencer is busy.
module first_fit_heap_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [16:0]                request_bytes,
  input  logic [ffha_pkg::OFF_W-1:0] payload_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [ffha_pkg::OFF_W-1:0] result_offset,
  output logic [ffha_pkg::SIZE_W-1:0] granted_bytes
);
  import ffha_pkg::*;

  // header store: {payload size, alloc bit}, indexed by header offset / 8
  logic [ENTRY_W-1:0] mem [0:(1<<IDX_W)-1];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  state_t state, state_next;
  logic [ADDR_W-1:0] h, h_next;               // header under inspection
  logic [ADDR_W-1:0] target, target_next;     // header of block being freed
  logic [SIZE_W-1:0] lsize, lsize_next;       // rounded request
  logic [ADDR_W-1:0] split_addr, split_addr_next;
  logic [SIZE_W-1:0] rem, rem_next;
  logic [ADDR_W-1:0] prev, prev_next;
  logic [SIZE_W-1:0] prev_size, prev_size_next;
  logic              prev_alloc, prev_alloc_next;
  logic              have_prev, have_prev_next;
  logic [SIZE_W-1:0] tsize, tsize_next;
  logic              nxt_ok, nxt_ok_next;
  logic [SIZE_W-1:0] newsize, newsize_next;
  logic [1:0]        res_status, res_status_next;
  logic [OFF_W-1:0]  res_off, res_off_next;
  logic [SIZE_W-1:0] res_gnt, res_gnt_next;

  logic              accept;
  logic              out_load;
  logic [SIZE_W-1:0] cur_size;
  logic              cur_alloc;
  logic [ADDR_W-1:0] walk_next;
  logic [SIZE_W-1:0] diff;
  logic [ADDR_W:0]   round_sum;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == S_RESP) && (!out_valid || !out_stall);
  assign cur_size  = rd_data[ENTRY_W-1:1];
  assign cur_alloc = rd_data[0];
  assign walk_next = h + HDR_BYTES + cur_size;      // shared adder for every walk step
  assign diff      = cur_size - lsize;
  assign round_sum = {1'b0, request_bytes} + {1'b0, ALIGN_LOW};

  // memory: one write port, one registered read port following the next header
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[h_next[IDX_W+2:3]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    h          <= h_next;
    target     <= target_next;
    lsize      <= lsize_next;
    split_addr <= split_addr_next;
    rem        <= rem_next;
    prev       <= prev_next;
    prev_size  <= prev_size_next;
    prev_alloc <= prev_alloc_next;
    have_prev  <= have_prev_next;
    tsize      <= tsize_next;
    nxt_ok     <= nxt_ok_next;
    newsize    <= newsize_next;
    res_status <= res_status_next;
    res_off    <= res_off_next;
    res_gnt    <= res_gnt_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= res_status;
      result_offset <= res_off;
      granted_bytes <= res_gnt;
    end
  end

  always_comb begin
    state_next      = state;
    h_next          = h;
    target_next     = target;
    lsize_next      = lsize;
    split_addr_next = split_addr;
    rem_next        = rem;
    prev_next       = prev;
    prev_size_next  = prev_size;
    prev_alloc_next = prev_alloc;
    have_prev_next  = have_prev;
    tsize_next      = tsize;
    nxt_ok_next     = nxt_ok;
    newsize_next    = newsize;
    res_status_next = res_status;
    res_off_next    = res_off;
    res_gnt_next    = res_gnt;
    mem_we          = 1'b0;
    mem_waddr       = h[IDX_W+2:3];
    mem_wdata       = {cur_size, 1'b0};

    case (state)
      S_INIT: begin
        // slot 0 becomes one free block spanning the arena
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = {INIT_SIZE, 1'b0};
        state_next = S_IDLE;
      end

      S_IDLE: begin
        h_next          = '0;
        res_off_next    = '0;
        res_gnt_next    = '0;
        have_prev_next  = 1'b0;
        if (accept) begin
          if (command == CMD_ALLOC) begin
            lsize_next = {round_sum[ADDR_W-1:3], 3'b000};
            if (request_bytes > HEAP_BYTES) begin
              res_status_next = ST_NO_FIT;
              state_next      = S_RESP;
            end else begin
              state_next = S_A_CHK;
            end
          end else begin
            target_next = {1'b0, payload_offset} - HDR_BYTES;
            if ({1'b0, payload_offset} < HDR_BYTES) begin
              res_status_next = ST_BAD_OFF;
              state_next      = S_RESP;
            end else begin
              state_next = S_F_WALK;
            end
          end
        end
      end

      S_A_CHK: begin
        if (cur_alloc || (cur_size < lsize)) begin
          // move on to the next header in address order
          h_next = walk_next;
          if (walk_next >= HEAP_BYTES) begin
            res_status_next = ST_NO_FIT;
            state_next      = S_RESP;
          end
        end else begin
          mem_we          = 1'b1;
          res_status_next = ST_OK;
          res_off_next    = OFF_W'(h + HDR_BYTES);
          if (diff <= SPLIT_SLACK) begin
            // leftover no larger than a header plus one alignment unit: take the whole block
            mem_wdata    = {cur_size, 1'b1};
            res_gnt_next = cur_size;
            state_next   = S_RESP;
          end else begin
            mem_wdata       = {lsize, 1'b1};
            res_gnt_next    = lsize;
            split_addr_next = h + HDR_BYTES + lsize;
            rem_next        = diff - HDR_BYTES;
            state_next      = S_A_SPLIT;
          end
        end
      end

      S_A_SPLIT: begin
        mem_we     = 1'b1;
        mem_waddr  = split_addr[IDX_W+2:3];
        mem_wdata  = {rem, 1'b0};
        state_next = S_RESP;
      end

      S_F_WALK: begin
        if ((h < HEAP_BYTES) && (h < target)) begin
          // remember the block in front of the target for the back merge
          prev_next       = h;
          prev_size_next  = cur_size;
          prev_alloc_next = cur_alloc;
          have_prev_next  = 1'b1;
          h_next          = walk_next;
        end else if ((h != target) || (h >= HEAP_BYTES) || !cur_alloc) begin
          res_status_next = ST_BAD_OFF;
          state_next      = S_RESP;
        end else begin
          tsize_next  = cur_size;
          nxt_ok_next = (walk_next < HEAP_BYTES);
          h_next      = walk_next;
          state_next  = S_F_NXT;
        end
      end

      S_F_NXT: begin
        // rd_data now holds the physical successor
        newsize_next = tsize;
        if (nxt_ok && !cur_alloc) begin
          newsize_next = tsize + HDR_BYTES + cur_size;
        end
        mem_we          = 1'b1;
        mem_waddr       = target[IDX_W+2:3];
        mem_wdata       = {newsize_next, 1'b0};
        res_status_next = ST_OK;
        if (have_prev && !prev_alloc) begin
          state_next = S_F_PREV;
        end else begin
          state_next = S_RESP;
        end
      end

      S_F_PREV: begin
        mem_we     = 1'b1;
        mem_waddr  = prev[IDX_W+2:3];
        mem_wdata  = {prev_size + HDR_BYTES + newsize, 1'b0};
        state_next = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a failed transaction never reports an offset or size
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (result_offset == '0) && (granted_bytes == '0))
    else $error("failed transaction carries nonzero payload");

  // grants are always a whole number of alignment units
  a_grant_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> (granted_bytes[2:0] == 3'b000))
    else $error("granted size not aligned");

  // the store is only written by the states that update headers
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_INIT) || (state == S_A_CHK) || (state == S_A_SPLIT) ||
               (state == S_F_NXT) || (state == S_F_PREV))
    else $error("header write outside update state");

  // an accepted transaction leaves idle at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accept");

endmodule

// ===== sim/first_fit_heap_allocator_tb.sv =====
// self-checking testbench for first_fit_heap_allocator: directed and random
// allocate/free traffic, with a scoreboard that mirrors the header store
// depends on ffha_pkg and the rtl top first_fit_heap_allocator
module first_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int ARENA   = int'(HEAP_BYTES);
  localparam int HDR     = int'(HDR_BYTES);
  localparam int SLACK   = int'(SPLIT_SLACK);
  localparam int SLOTS   = ARENA / 8 + 1;
  localparam int N_RAND  = 1080;
  localparam int N_CALM  = 100;   // last items run with no idling

  int errors = 0;

  // one line per mismatch, counted
  task automatic report(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // header-store mirror plus the queue of responses still owed
  class alloc_scoreboard;
    int unsigned hdr_mem[SLOTS];
    logic [1:0]  owed_status[$];
    logic [15:0] owed_offset[$];
    logic [16:0] owed_bytes[$];
    int          live[$];      // payload offsets currently allocated
    int          n_ok, n_nofit, n_bad;

    function new();
      foreach (hdr_mem[i]) hdr_mem[i] = 0;
      hdr_mem[0] = int'(INIT_SIZE) << 1;
    endfunction

    function int size_at(int h);
      if (h / 8 >= SLOTS) return 0;
      return hdr_mem[h / 8] >> 1;
    endfunction

    function bit used_at(int h);
      if (h / 8 >= SLOTS) return 0;
      return hdr_mem[h / 8][0];
    endfunction

    function void put(int h, int sz, bit used);
      if (h / 8 < SLOTS) hdr_mem[h / 8] = (sz << 1) | used;
    endfunction

    function void drop_live(int pay);
      foreach (live[i]) if (live[i] == pay) begin
        live.delete(i);
        return;
      end
    endfunction

    // predict one accepted transaction
    function void note(logic cmd, logic [16:0] req, logic [15:0] pay);
      logic [1:0] st;
      int off, gr, lsz, h, sz, tgt, prv, nxt;
      bit have_prv;
      st = ST_NO_FIT;
      off = 0;
      gr = 0;
      if (cmd == CMD_ALLOC) begin
        if (int'(req) <= ARENA) begin
          lsz = ((int'(req) + 7) / 8) * 8;
          h = 0;
          while (h < ARENA) begin
            sz = size_at(h);
            if (!used_at(h) && sz >= lsz) begin
              if (sz - lsz <= SLACK) put(h, sz, 1);
              else begin
                put(h, lsz, 1);
                put(h + HDR + lsz, sz - lsz - HDR, 0);
                sz = lsz;
              end
              st = ST_OK;
              off = (h + HDR) & 16'hffff;
              gr = sz;
              live.push_back(off);
              break;
            end
            h = h + HDR + sz;
          end
        end
      end else begin
        st = ST_BAD_OFF;
        if (int'(pay) >= HDR) begin
          tgt = int'(pay) - HDR;
          h = 0;
          prv = 0;
          have_prv = 0;
          while (h < ARENA && h < tgt) begin
            prv = h;
            have_prv = 1;
            h = h + HDR + size_at(h);
          end
          if (h == tgt && h < ARENA && used_at(h)) begin
            st = ST_OK;
            put(h, size_at(h), 0);
            nxt = h + HDR + size_at(h);
            if (nxt < ARENA && !used_at(nxt)) put(h, size_at(h) + HDR + size_at(nxt), 0);
            if (have_prv && !used_at(prv)) put(prv, size_at(prv) + HDR + size_at(h), 0);
            drop_live(int'(pay));
          end
        end
      end
      case (st)
        ST_OK:     n_ok++;
        ST_NO_FIT: n_nofit++;
        default:   n_bad++;
      endcase
      owed_status.push_back(st);
      owed_offset.push_back(off[15:0]);
      owed_bytes.push_back(gr[16:0]);
    endfunction

    // compare one accepted response with the oldest prediction
    task check(logic [1:0] st, logic [15:0] off, logic [16:0] gr);
      logic [1:0]  e_st;
      logic [15:0] e_off;
      logic [16:0] e_gr;
      if (owed_status.size() == 0) begin
        report($sformatf("unexpected response status=%0d offset=%0d bytes=%0d",
                         st, off, gr));
        return;
      end
      e_st = owed_status.pop_front();
      e_off = owed_offset.pop_front();
      e_gr = owed_bytes.pop_front();
      if (st !== e_st) report($sformatf("status %0d, expected %0d", st, e_st));
      if (off !== e_off) report($sformatf("result_offset %0d, expected %0d", off, e_off));
      if (gr !== e_gr) report($sformatf("granted_bytes %0d, expected %0d", gr, e_gr));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic        command = CMD_ALLOC;
  logic [16:0] request_bytes = '0;
  logic [15:0] payload_offset = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic [15:0] result_offset;
  logic [16:0] granted_bytes;

  bit calm = 0;        // set for the final stretch: no idling on either side
  bit stim_done = 0;
  alloc_scoreboard sb = new();

  always #5 clk = ~clk;

  first_fit_heap_allocator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .request_bytes(request_bytes), .payload_offset(payload_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_offset(result_offset), .granted_bytes(granted_bytes)
  );

  // offer one transaction; an optional idle burst goes first
  task automatic send(logic cmd, logic [16:0] req, logic [15:0] pay);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    command <= cmd;
    request_bytes <= req;
    payload_offset <= pay;
    do @(posedge clk); while (in_stall);
    sb.note(cmd, req, pay);
  endtask

  task automatic send_alloc(logic [16:0] req);
    send(CMD_ALLOC, req, 16'($urandom));
  endtask

  task automatic send_free(logic [15:0] pay);
    send(CMD_FREE, 17'($urandom), pay);
  endtask

  // pick a live offset, or 0 when nothing is allocated
  function automatic int pick_live();
    if (sb.live.size() == 0) return 0;
    return sb.live[$urandom_range(0, sb.live.size() - 1)];
  endfunction

  // receiver stalls in random bursts until the calm stretch
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 16);
        repeat (n) begin
          out_stall <= 1;
          @(negedge clk);
        end
      end
      n = $urandom_range(1, 16);
      repeat (n) begin
        out_stall <= 0;
        @(negedge clk);
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check(status, result_offset, granted_bytes);
  end

  // stimulus
  initial begin
    int a, b, pick, sz;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: field extremes, zero request, oversized, bad frees, coalescing
    send_alloc(17'd0);                 // zero-byte block
    send_alloc(17'd1);
    send_alloc(17'd8);
    a = pick_live();
    send_free(16'd0);                  // below the header size
    send_free(16'd39);
    send_free(16'hffff);
    send_free(16'(a + 8));             // inside a block
    send_alloc(17'd65536);             // larger than the initial free block
    send_alloc(17'd65537);             // above the arena
    send_alloc(17'h1ffff);
    send_free(16'd40);                 // first block freed
    send_free(16'd40);                 // double free
    send_free(16'(sb.live[0]));        // merges with the freed neighbor
    send_free(16'(pick_live()));       // now everything merged back
    send_alloc(17'(int'(INIT_SIZE)));  // whole arena in one block
    send_free(16'd40);
    send_alloc(17'(int'(INIT_SIZE) - 48)); // leftover exactly header plus 8: kept whole
    send_free(16'd40);
    send_alloc(17'(int'(INIT_SIZE) - 56)); // leftover large enough to split
    send_alloc(17'd0);
    send_free(16'd40);
    send_free(16'(pick_live()));
    send_alloc(17'd12345);
    send_free(16'(pick_live()));

    // random: mostly small allocs and frees of live blocks, some noise
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND - N_CALM) calm = 1;
      pick = $urandom_range(0, 99);
      if (sb.live.size() > 40) pick = 50 + pick / 2;
      if (pick < 50) begin
        b = $urandom_range(0, 99);
        if (b < 80) sz = $urandom_range(0, 300);
        else if (b < 92) sz = $urandom_range(0, 4096);
        else if (b < 96) sz = $urandom_range(0, 65536);
        else sz = $urandom_range(0, 17'h1ffff);
        send_alloc(17'(sz));
      end else if (pick < 88 && sb.live.size() > 0) begin
        send_free(16'(pick_live()));
      end else begin
        b = $urandom_range(0, 3);
        case (b)
          0: send_free(16'($urandom));
          1: send_free(16'(pick_live() + 8 * $urandom_range(1, 4)));
          2: send_free(16'(pick_live() - 8));
          default: send_free(16'($urandom_range(0, 47)));
        endcase
      end
    end
    @(negedge clk);
    in_valid <= 0;

    while (sb.owed_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.owed_status.size() != 0) report("response left over after drain");
    $display("covered %0d transactions: %0d ok, %0d no fit, %0d bad offset",
             sb.n_ok + sb.n_nofit + sb.n_bad, sb.n_ok, sb.n_nofit, sb.n_bad);
    $display("directed extremes, split and merge cases, then random traffic with idling");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("timeout waiting for the block");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
